// File: hw/rtl/lcm_pkg.sv
// ----------------------------------------------------------------------------
// Log-scaled colormap package
// Shared widths, codes, request formats and the colour table of the pipeline.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int GAMMA_TABLE_BITS_DEF = 10;

    localparam int DENSITY_W   = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 1;

    localparam int EXP_W  = 5;
    localparam int FRAC_W = 16;
    localparam int LOG_W  = EXP_W + FRAC_W;
    localparam int MANT_W = 32;

    localparam int LANES        = 3;
    localparam int LANE_DENSITY = 0;
    localparam int LANE_FLOOR   = 1;
    localparam int LANE_CEILING = 2;

    localparam int Q16_W   = 16;
    localparam int COLOR_W = 8;
    localparam int SEG_W   = 4;

    localparam logic [Q16_W:0]     ONE_Q16    = 17'h10000;
    localparam logic [COLOR_W-1:0] GRAY_LEVEL = 8'd128;
    localparam logic [COLOR_W-1:0] FULL_LEVEL = 8'd255;
    localparam logic [COLOR_W-1:0] ZERO_LEVEL = 8'd0;
    localparam logic [SEG_W-1:0]   SEG_MID    = 4'd5;
    localparam logic [SEG_W-1:0]   SEG_TOP    = 4'd10;

    localparam logic [CFG_W-1:0] FLOOR_RESET   = 32'd1;
    localparam logic [CFG_W-1:0] CEILING_RESET = 32'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DENSITY_FLOOR,
        REG_DENSITY_CEILING
    } lcm_reg_t;

    typedef enum logic [1:0] {
        CLASS_BOTH,
        CLASS_NEITHER,
        CLASS_TERRAIN,
        CLASS_MESH
    } lcm_class_t;

    typedef enum logic [2:0] {
        SEL_MAP,
        SEL_GRAY,
        SEL_BLUE,
        SEL_GREEN,
        SEL_MID,
        SEL_TOP
    } lcm_sel_t;

    typedef struct packed {
        logic       valid;
        lcm_class_t pclass;
        lcm_sel_t   sel;
    } lcm_tag_t;

    typedef struct packed {
        logic                 seen_by_mesh;
        logic                 seen_by_terrain;
        logic [DENSITY_W-1:0] density;
    } lcm_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [1:0]         pixel_class;
    } lcm_out_t;

    // Eleven-point colour scale, packed as {red, green, blue}.
    function automatic logic [3*COLOR_W-1:0] viridis_point(input logic [SEG_W-1:0] seg);
        logic [3*COLOR_W-1:0] c;
        case (seg)
            4'd0:    c = {8'd68,  8'd1,   8'd84};
            4'd1:    c = {8'd71,  8'd15,  8'd107};
            4'd2:    c = {8'd72,  8'd36,  8'd117};
            4'd3:    c = {8'd67,  8'd55,  8'd125};
            4'd4:    c = {8'd56,  8'd75,  8'd126};
            4'd5:    c = {8'd42,  8'd95,  8'd125};
            4'd6:    c = {8'd32,  8'd115, 8'd117};
            4'd7:    c = {8'd34,  8'd135, 8'd97};
            4'd8:    c = {8'd68,  8'd154, 8'd68};
            4'd9:    c = {8'd122, 8'd170, 8'd40};
            4'd10:   c = {8'd253, 8'd231, 8'd37};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/log_scaled_colormap_pixel.sv
// ----------------------------------------------------------------------------
// Log-scaled colormap pixel
// Colours one pixel per request from two visibility flags and a density on a
// base-2 logarithmic scale between two configured bounds.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  in        input      in_valid/in_stall  seen_by_mesh, seen_by_terrain, density
//  out       output     out_valid/out_stall red, green, blue, pixel_class
//  cfg       input      cfg_write          cfg_index, cfg_data (floor, ceiling)
//
// A request is taken in every cycle in which in_stall is low; each passes
// through the logarithm, range division, gamma and colour stages in turn.
// The whole pipeline moves as one: it holds only while the output register
// carries a pixel that is stalled, and in_stall is raised in exactly those
// cycles, so nothing is dropped or repeated.
// Reset clears every valid bit and loads the scale bounds with 1 and 10.
//
module log_scaled_colormap_pixel
#(
    parameter int GAMMA_TABLE_BITS = lcm_pkg::GAMMA_TABLE_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lcm_pkg::lcm_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lcm_pkg::lcm_out_t                 out_data,
    input  logic                              cfg_write,
    input  logic [lcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lcm_pkg::CFG_W-1:0]         cfg_data
);

    logic [lcm_pkg::CFG_W-1:0] density_floor_reg;
    logic [lcm_pkg::CFG_W-1:0] density_ceiling_reg;

    logic                                           advance;
    lcm_pkg::lcm_tag_t                              entry_tag;
    logic [lcm_pkg::LANES-1:0][lcm_pkg::MANT_W-1:0] lane_value;
    lcm_pkg::lcm_tag_t                              log_tag;
    logic [lcm_pkg::LANES-1:0][lcm_pkg::LOG_W-1:0]  lane_log;
    lcm_pkg::lcm_tag_t                              div_tag;
    logic [lcm_pkg::Q16_W-1:0]                      norm_value;
    lcm_pkg::lcm_tag_t                              gamma_tag;
    logic [lcm_pkg::Q16_W-1:0]                      gamma_value;

    // The user must write configuration only while the pipeline is empty, so the
    // bounds can be sampled along with each request; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_floor_reg   <= lcm_pkg::FLOOR_RESET;
            density_ceiling_reg <= lcm_pkg::CEILING_RESET;
        end
        else if (cfg_write)
        begin
            case (lcm_pkg::lcm_reg_t'(cfg_index))
                lcm_pkg::REG_DENSITY_FLOOR:   density_floor_reg   <= cfg_data;
                lcm_pkg::REG_DENSITY_CEILING: density_ceiling_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Every stage advances unless the finished pixel is held at the output.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // The visibility flags decide the class and, apart from the both-visible
    // case, the colour. A zero density, a zero floor or a ceiling not above
    // the floor gives gray even when both tests see the point.
    always_comb
    begin
        entry_tag.valid = in_valid;
        if (in_data.seen_by_mesh && in_data.seen_by_terrain)
        begin
            entry_tag.pclass = lcm_pkg::CLASS_BOTH;
            if ((in_data.density == '0) || (density_floor_reg == '0) ||
                (density_ceiling_reg <= density_floor_reg))
            begin
                entry_tag.sel = lcm_pkg::SEL_GRAY;
            end
            else
            begin
                entry_tag.sel = lcm_pkg::SEL_MAP;
            end
        end
        else if (!in_data.seen_by_mesh && !in_data.seen_by_terrain)
        begin
            entry_tag.pclass = lcm_pkg::CLASS_NEITHER;
            entry_tag.sel    = lcm_pkg::SEL_GRAY;
        end
        else if (in_data.seen_by_terrain)
        begin
            entry_tag.pclass = lcm_pkg::CLASS_TERRAIN;
            entry_tag.sel    = lcm_pkg::SEL_BLUE;
        end
        else
        begin
            entry_tag.pclass = lcm_pkg::CLASS_MESH;
            entry_tag.sel    = lcm_pkg::SEL_GREEN;
        end
    end

    always_comb
    begin
        lane_value[lcm_pkg::LANE_DENSITY] = in_data.density;
        lane_value[lcm_pkg::LANE_FLOOR]   = density_floor_reg;
        lane_value[lcm_pkg::LANE_CEILING] = density_ceiling_reg;
    end

    lcm_log2 u_log2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .tag_in    (entry_tag),
        .value     (lane_value),
        .tag_out   (log_tag),
        .log_value (lane_log)
    );

    lcm_div u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .tag_in      (log_tag),
        .dens_log    (lane_log[lcm_pkg::LANE_DENSITY]),
        .log_floor   (lane_log[lcm_pkg::LANE_FLOOR]),
        .log_ceiling (lane_log[lcm_pkg::LANE_CEILING]),
        .tag_out     (div_tag),
        .norm_value  (norm_value)
    );

    lcm_gamma
    #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    )
    u_gamma
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .tag_in      (div_tag),
        .norm_value  (norm_value),
        .tag_out     (gamma_tag),
        .gamma_value (gamma_value)
    );

    lcm_color u_color
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .tag_in      (gamma_tag),
        .gamma_value (gamma_value),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

    // The input is only held back when a finished pixel waits at the output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no pixel held at the output");

    a_neither_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.pixel_class == lcm_pkg::CLASS_NEITHER)) |->
        ((out_data.red == lcm_pkg::GRAY_LEVEL) && (out_data.green == lcm_pkg::GRAY_LEVEL) &&
         (out_data.blue == lcm_pkg::GRAY_LEVEL)))
        else $error("hidden pixel is not gray");

    a_terrain_blue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.pixel_class == lcm_pkg::CLASS_TERRAIN)) |->
        ((out_data.red == lcm_pkg::ZERO_LEVEL) && (out_data.blue == lcm_pkg::FULL_LEVEL)))
        else $error("terrain-only pixel is not blue");

    a_mesh_green: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.pixel_class == lcm_pkg::CLASS_MESH)) |->
        ((out_data.red == lcm_pkg::ZERO_LEVEL) && (out_data.green == lcm_pkg::FULL_LEVEL)))
        else $error("mesh-only pixel is not green");

endmodule

// File: hw/rtl/lcm_log2.sv
// ----------------------------------------------------------------------------
// Base-2 logarithm pipeline
// Three lanes: normalise, then one mantissa squaring per stage for each
// fraction bit, giving Q5.16 logarithms.
// ----------------------------------------------------------------------------
module lcm_log2
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           en,
    input  lcm_pkg::lcm_tag_t                              tag_in,
    input  logic [lcm_pkg::LANES-1:0][lcm_pkg::MANT_W-1:0] value,
    output lcm_pkg::lcm_tag_t                              tag_out,
    output logic [lcm_pkg::LANES-1:0][lcm_pkg::LOG_W-1:0]  log_value
);

    localparam int STAGES = lcm_pkg::FRAC_W;

    lcm_pkg::lcm_tag_t                              tag_reg  [0:STAGES];
    logic [lcm_pkg::LANES-1:0][lcm_pkg::EXP_W-1:0]  exp_reg  [0:STAGES];
    logic [lcm_pkg::LANES-1:0][lcm_pkg::MANT_W-1:0] mant_reg [0:STAGES];
    logic [lcm_pkg::LANES-1:0][lcm_pkg::FRAC_W-1:0] frac_reg [0:STAGES];

    logic [lcm_pkg::LANES-1:0][lcm_pkg::EXP_W-1:0]  exp0_next;
    logic [lcm_pkg::LANES-1:0][lcm_pkg::MANT_W-1:0] mant0_next;
    logic [lcm_pkg::LANES-1:0][lcm_pkg::MANT_W-1:0] mant_next [1:STAGES];
    logic [lcm_pkg::LANES-1:0][lcm_pkg::FRAC_W-1:0] frac_next [1:STAGES];

    // The exponent is the position of the top set bit; the mantissa is
    // shifted up so that this bit lands in bit 31.
    always_comb
    begin
        for (int l = 0; l < lcm_pkg::LANES; l++)
        begin
            exp0_next[l] = '0;
            for (int b = 0; b < lcm_pkg::MANT_W; b++)
            begin
                if (value[l][b])
                begin
                    exp0_next[l] = lcm_pkg::EXP_W'(b);
                end
            end
            mant0_next[l] = value[l] << (5'd31 - exp0_next[l]);
        end
    end

    // Each square doubles the logarithm; an overflow past 2.0 is the next bit.
    always_comb
    begin
        logic [2*lcm_pkg::MANT_W-1:0] sq;
        logic [lcm_pkg::MANT_W:0]     m2;
        for (int k = 1; k <= STAGES; k++)
        begin
            for (int l = 0; l < lcm_pkg::LANES; l++)
            begin
                sq = 64'(mant_reg[k-1][l]) * 64'(mant_reg[k-1][l]);
                m2 = sq[63:31];
                mant_next[k][l] = m2[32] ? m2[32:1] : m2[31:0];
                frac_next[k][l] = frac_reg[k-1][l];
                frac_next[k][l][STAGES-k] = m2[32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int k = 1; k <= STAGES; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exp_reg[0]  <= exp0_next;
            mant_reg[0] <= mant0_next;
            frac_reg[0] <= '0;
            for (int k = 1; k <= STAGES; k++)
            begin
                exp_reg[k]  <= exp_reg[k-1];
                mant_reg[k] <= mant_next[k];
                frac_reg[k] <= frac_next[k];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < lcm_pkg::LANES; l++)
        begin
            log_value[l] = {exp_reg[STAGES][l], frac_reg[STAGES][l]};
        end
    end

    assign tag_out = tag_reg[STAGES];

endmodule

// File: hw/rtl/lcm_div.sv
// ----------------------------------------------------------------------------
// Log range normaliser
// Compares the density log against the scale ends, then divides the offset
// by the range with one restoring step per stage, giving a Q0.16 value.
// ----------------------------------------------------------------------------
module lcm_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  lcm_pkg::lcm_tag_t                tag_in,
    input  logic [lcm_pkg::LOG_W-1:0]        dens_log,
    input  logic [lcm_pkg::LOG_W-1:0]        log_floor,
    input  logic [lcm_pkg::LOG_W-1:0]        log_ceiling,
    output lcm_pkg::lcm_tag_t                tag_out,
    output logic [lcm_pkg::Q16_W-1:0]        norm_value
);

    localparam int STAGES = lcm_pkg::Q16_W;
    localparam int W      = lcm_pkg::LOG_W;

    lcm_pkg::lcm_tag_t          tag_reg [0:STAGES];
    logic [W-1:0]               rem_reg [0:STAGES];
    logic [W-1:0]               den_reg [0:STAGES];
    logic [lcm_pkg::Q16_W-1:0]  quo_reg [0:STAGES];

    lcm_pkg::lcm_tag_t          tag0_next;
    logic [W-1:0]               rem0_next;
    logic [W-1:0]               rem_next [1:STAGES];
    logic [lcm_pkg::Q16_W-1:0]  quo_next [1:STAGES];

    // A vanished range gives the middle colour, a density at or above the
    // ceiling the top colour; at or below the floor the offset is zero.
    always_comb
    begin
        tag0_next = tag_in;
        if (tag_in.sel == lcm_pkg::SEL_MAP)
        begin
            if (log_ceiling <= log_floor)
            begin
                tag0_next.sel = lcm_pkg::SEL_MID;
            end
            else if (dens_log >= log_ceiling)
            begin
                tag0_next.sel = lcm_pkg::SEL_TOP;
            end
        end
        rem0_next = (dens_log > log_floor) ? (dens_log - log_floor) : '0;
    end

    always_comb
    begin
        logic [W:0] shifted;
        for (int k = 1; k <= STAGES; k++)
        begin
            shifted = {rem_reg[k-1], 1'b0};
            if (shifted >= {1'b0, den_reg[k-1]})
            begin
                rem_next[k] = W'(shifted - {1'b0, den_reg[k-1]});
                quo_next[k] = {quo_reg[k-1][lcm_pkg::Q16_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shifted[W-1:0];
                quo_next[k] = {quo_reg[k-1][lcm_pkg::Q16_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag0_next;
            for (int k = 1; k <= STAGES; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem0_next;
            den_reg[0] <= log_ceiling - log_floor;
            quo_reg[0] <= '0;
            for (int k = 1; k <= STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_reg[k-1];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign tag_out    = tag_reg[STAGES];
    assign norm_value = quo_reg[STAGES];

endmodule

// File: hw/rtl/lcm_gamma.sv
// ----------------------------------------------------------------------------
// Gamma stage
// Raises the Q0.16 value to the power 0.6 with an interpolated lookup table.
// ----------------------------------------------------------------------------
module lcm_gamma
#(
    parameter int GAMMA_TABLE_BITS = lcm_pkg::GAMMA_TABLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  lcm_pkg::lcm_tag_t         tag_in,
    input  logic [lcm_pkg::Q16_W-1:0] norm_value,
    output lcm_pkg::lcm_tag_t         tag_out,
    output logic [lcm_pkg::Q16_W-1:0] gamma_value
);

    localparam int SH        = lcm_pkg::Q16_W - GAMMA_TABLE_BITS;
    localparam int IDX_W     = GAMMA_TABLE_BITS + 1;
    localparam int TAB_SIZE  = (1 << GAMMA_TABLE_BITS) + 1;
    localparam int SHIFT_EXP = 80 - 3 * GAMMA_TABLE_BITS;
    localparam logic [lcm_pkg::Q16_W-1:0] FRAC_MASK = lcm_pkg::Q16_W'((32'd1 << SH) - 32'd1);

    typedef logic [lcm_pkg::Q16_W:0] gtab_t [0:TAB_SIZE-1];

    // Entry i is the largest g with g^5 <= i^3 * 2^(80-3B), which is
    // floor(65536 * (i / 2^B)^0.6); the last entry is exactly one.
    function automatic gtab_t build_gamma();
        gtab_t        tab;
        logic [47:0]  i3;
        logic [127:0] rhs;
        logic [79:0]  c80;
        logic [79:0]  p5;
        logic [15:0]  g;
        logic [15:0]  c;
        for (int i = 0; i < TAB_SIZE - 1; i++)
        begin
            i3  = 48'(i);
            i3  = i3 * 48'(i) * 48'(i);
            rhs = 128'(i3) << SHIFT_EXP;
            g   = '0;
            for (int b = 15; b >= 0; b--)
            begin
                c   = g | (16'd1 << b);
                c80 = 80'(c);
                p5  = c80 * c80 * c80 * c80 * c80;
                if (128'(p5) <= rhs)
                begin
                    g = c;
                end
            end
            tab[i] = 17'(g);
        end
        tab[TAB_SIZE-1] = lcm_pkg::ONE_Q16;
        return tab;
    endfunction

    localparam gtab_t GAMMA_TAB = build_gamma();

    lcm_pkg::lcm_tag_t         tag_reg [0:1];
    logic [lcm_pkg::Q16_W:0]   lo_reg;
    logic [lcm_pkg::Q16_W:0]   hi_reg;
    logic [lcm_pkg::Q16_W-1:0] frac_reg;
    logic [lcm_pkg::Q16_W-1:0] gamma_reg;

    logic [lcm_pkg::Q16_W-1:0] idx_full;
    logic [IDX_W-1:0]          idx_lo;
    logic [IDX_W-1:0]          idx_hi;
    logic [lcm_pkg::Q16_W:0]   span;
    logic [2*lcm_pkg::Q16_W:0] prod;
    logic [lcm_pkg::Q16_W-1:0] gamma_next;

    assign idx_full = norm_value >> SH;
    assign idx_lo   = {1'b0, idx_full[GAMMA_TABLE_BITS-1:0]};
    assign idx_hi   = idx_lo + IDX_W'(1);

    assign span       = hi_reg - lo_reg;
    assign prod       = 33'(span) * 33'(frac_reg);
    assign gamma_next = lcm_pkg::Q16_W'(lo_reg + 17'(prod >> SH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
            tag_reg[1] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            tag_reg[1] <= tag_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg    <= GAMMA_TAB[idx_lo];
            hi_reg    <= GAMMA_TAB[idx_hi];
            frac_reg  <= norm_value & FRAC_MASK;
            gamma_reg <= gamma_next;
        end
    end

    assign tag_out     = tag_reg[1];
    assign gamma_value = gamma_reg;

endmodule

// File: hw/rtl/lcm_color.sv
// ----------------------------------------------------------------------------
// Colour stage
// Interpolates the colour scale at the gamma value, or picks the fixed colour of
// the other selections, and holds the result.
module lcm_color
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  lcm_pkg::lcm_tag_t         tag_in,
    input  logic [lcm_pkg::Q16_W-1:0] gamma_value,
    output logic                      out_valid,
    output lcm_pkg::lcm_out_t         out_data
);

    lcm_pkg::lcm_tag_t           tag_reg;
    logic [lcm_pkg::SEG_W-1:0]   seg_reg;
    logic [lcm_pkg::Q16_W-1:0]   t_reg;
    logic                        valid_reg;
    lcm_pkg::lcm_out_t           out_reg;

    logic [19:0]                  scaled;
    logic [3*lcm_pkg::COLOR_W-1:0] c_lo;
    logic [3*lcm_pkg::COLOR_W-1:0] c_hi;
    logic [3*lcm_pkg::COLOR_W-1:0] mapped;
    lcm_pkg::lcm_out_t            out_next;

    assign scaled = 20'(gamma_value) * 20'd10;

    assign c_lo = lcm_pkg::viridis_point(seg_reg);
    assign c_hi = lcm_pkg::viridis_point(seg_reg + 4'd1);

    always_comb
    begin
        logic [lcm_pkg::COLOR_W-1:0] c1;
        logic [lcm_pkg::COLOR_W-1:0] c2;
        logic signed [8:0]           diff;
        logic signed [16:0]          ts;
        logic signed [25:0]          prod;
        logic signed [26:0]          acc;
        for (int ch = 0; ch < 3; ch++)
        begin
            c1   = c_lo[(2-ch)*lcm_pkg::COLOR_W +: lcm_pkg::COLOR_W];
            c2   = c_hi[(2-ch)*lcm_pkg::COLOR_W +: lcm_pkg::COLOR_W];
            diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
            ts   = $signed({1'b0, t_reg});
            prod = 26'(diff) * 26'(ts);
            acc  = $signed({3'b0, c1, 16'b0}) + 27'(prod);
            mapped[(2-ch)*lcm_pkg::COLOR_W +: lcm_pkg::COLOR_W] = acc[23:16];
        end
    end

    always_comb
    begin
        out_next.pixel_class = tag_reg.pclass;
        case (tag_reg.sel)
            lcm_pkg::SEL_MAP:
            begin
                {out_next.red, out_next.green, out_next.blue} = mapped;
            end
            lcm_pkg::SEL_BLUE:
            begin
                {out_next.red, out_next.green, out_next.blue} =
                    {lcm_pkg::ZERO_LEVEL, lcm_pkg::ZERO_LEVEL, lcm_pkg::FULL_LEVEL};
            end
            lcm_pkg::SEL_GREEN:
            begin
                {out_next.red, out_next.green, out_next.blue} =
                    {lcm_pkg::ZERO_LEVEL, lcm_pkg::FULL_LEVEL, lcm_pkg::ZERO_LEVEL};
            end
            lcm_pkg::SEL_MID:
            begin
                {out_next.red, out_next.green, out_next.blue} =
                    lcm_pkg::viridis_point(lcm_pkg::SEG_MID);
            end
            lcm_pkg::SEL_TOP:
            begin
                {out_next.red, out_next.green, out_next.blue} =
                    lcm_pkg::viridis_point(lcm_pkg::SEG_TOP);
            end
            default:
            begin
                {out_next.red, out_next.green, out_next.blue} =
                    {lcm_pkg::GRAY_LEVEL, lcm_pkg::GRAY_LEVEL, lcm_pkg::GRAY_LEVEL};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tag_reg   <= tag_in;
            valid_reg <= tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= scaled[19:16];
            t_reg   <= scaled[15:0];
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = out_reg;

endmodule
